[hdl/rect_to_polar_converter_defines.svh]
// ----------------------------------------------------------------------------
// rect_to_polar_converter_defines
// assertion macros shared by the checker files of the converter
// ----------------------------------------------------------------------------
`ifndef RECT_TO_POLAR_CONVERTER_DEFINES_SVH
`define RECT_TO_POLAR_CONVERTER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define R2P_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("r2p check failed");

// antecedent must be followed by the consequent a fixed number of cycles later
`define R2P_ASSERT_DELAY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("r2p latency check failed");

`endif

[hdl/r2p_pkg.sv]
// ----------------------------------------------------------------------------
// r2p_pkg
// shared constants, tables and types of the rectangular to polar converter
// ----------------------------------------------------------------------------
package r2p_pkg;

  localparam int DEF_COORD_WIDTH   = 16;
  localparam int DEF_CORDIC_STAGES = 16;
  localparam int GUARD_BITS        = 16;
  localparam int ANGLE_WIDTH       = 16;
  localparam int ACC_WIDTH         = 32;
  localparam int GAIN_WIDTH        = 32;
  localparam int GAIN_FRAC         = 31;
  // input register, two gain stages and the output register
  localparam int PIPE_EXTRA        = 4;

  typedef struct packed {
    logic valid;
    logic zero;
  } r2p_ctl_t;

  // atan(2^-i) in units where 2^31 is pi
  function automatic logic [ACC_WIDTH-1:0] atan_entry(input int unsigned i);
    logic [ACC_WIDTH-1:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // inverse cordic gain in q31 for a given stage count, 16 and up share one value
  function automatic logic [GAIN_WIDTH-1:0] inv_gain(input int unsigned n);
    logic [GAIN_WIDTH-1:0] v;
    case (n)
      0:  v = 32'd2147483648;
      1:  v = 32'd1518500250;
      2:  v = 32'd1358187914;
      3:  v = 32'd1317635818;
      4:  v = 32'd1307460872;
      5:  v = 32'd1304914694;
      6:  v = 32'd1304277995;
      7:  v = 32'd1304118810;
      8:  v = 32'd1304079014;
      9:  v = 32'd1304069064;
      10: v = 32'd1304066577;
      11: v = 32'd1304065955;
      12: v = 32'd1304065800;
      13: v = 32'd1304065761;
      14: v = 32'd1304065751;
      15: v = 32'd1304065749;
      default: v = 32'd1304065748;
    endcase
    return v;
  endfunction

endpackage

[hdl/r2p_prep.sv]
// ----------------------------------------------------------------------------
// r2p_prep
// input register: folds the left half plane and scales by the guard bits
// ----------------------------------------------------------------------------
module r2p_prep
  import r2p_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int XW          = DEF_COORD_WIDTH + GUARD_BITS + 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  output logic signed [XW-1:0]          x_out,
  output logic signed [XW-1:0]          y_out,
  output logic        [ACC_WIDTH-1:0]   acc_out,
  output r2p_ctl_t                      ctl_out
);

  logic signed [XW-1:0] xe;
  logic signed [XW-1:0] ye;
  logic                 x_neg;

  assign xe    = XW'(x_coord);
  assign ye    = XW'(y_coord);
  assign x_neg = x_coord[COORD_WIDTH-1];

  always_ff @(posedge clk) begin
    if (x_neg) begin
      x_out   <= (-xe) <<< GUARD_BITS;
      y_out   <= (-ye) <<< GUARD_BITS;
      acc_out <= ACC_WIDTH'(1) << (ACC_WIDTH - 1);
    end else begin
      x_out   <= xe <<< GUARD_BITS;
      y_out   <= ye <<< GUARD_BITS;
      acc_out <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out.valid <= accept;
      ctl_out.zero  <= (x_coord == '0) && (y_coord == '0);
    end
  end

endmodule

[hdl/r2p_cell.sv]
// ----------------------------------------------------------------------------
// r2p_cell
// one cordic vectoring micro-rotation with its own pipeline register
// ----------------------------------------------------------------------------
module r2p_cell
  import r2p_pkg::*;
#(
  parameter int                   XW    = DEF_COORD_WIDTH + GUARD_BITS + 3,
  parameter int                   SHIFT = 0,
  parameter logic [ACC_WIDTH-1:0] ATAN  = '0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic signed [XW-1:0]        x_in,
  input  logic signed [XW-1:0]        y_in,
  input  logic        [ACC_WIDTH-1:0] acc_in,
  input  r2p_ctl_t                    ctl_in,
  output logic signed [XW-1:0]        x_out,
  output logic signed [XW-1:0]        y_out,
  output logic        [ACC_WIDTH-1:0] acc_out,
  output r2p_ctl_t                    ctl_out
);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  // arithmetic shifts round toward minus infinity
  assign dx = y_in >>> SHIFT;
  assign dy = x_in >>> SHIFT;

  always_ff @(posedge clk) begin
    if (!y_in[XW-1]) begin
      x_out   <= x_in + dx;
      y_out   <= y_in - dy;
      acc_out <= acc_in + ATAN;
    end else begin
      x_out   <= x_in - dx;
      y_out   <= y_in + dy;
      acc_out <= acc_in - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

endmodule

[hdl/r2p_gain.sv]
// ----------------------------------------------------------------------------
// r2p_gain
// gain compensation, angle rounding and output register
// ----------------------------------------------------------------------------
module r2p_gain
  import r2p_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int XW          = DEF_COORD_WIDTH + GUARD_BITS + 3,
  parameter int STAGES      = DEF_CORDIC_STAGES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [XW-1:0]          x_in,
  input  logic        [ACC_WIDTH-1:0]   acc_in,
  input  r2p_ctl_t                      ctl_in,
  output logic                          done,
  output logic        [COORD_WIDTH-1:0] magnitude,
  output logic signed [ANGLE_WIDTH-1:0] angle
);

  localparam int AW          = XW - 1;
  localparam int LO_W        = (AW + 1) / 2;
  localparam int HI_W        = AW - LO_W;
  localparam int PW          = AW + GAIN_WIDTH;
  localparam int SCALE_SHIFT = GAIN_FRAC + GUARD_BITS;
  localparam int MW          = PW - SCALE_SHIFT;
  localparam int GIDX        = (STAGES > 16) ? 16 : STAGES;
  localparam logic [GAIN_WIDTH-1:0] GAIN = inv_gain(GIDX);
  localparam logic [PW-1:0] RND = PW'(1) << (SCALE_SHIFT - 1);
  localparam logic [ACC_WIDTH-1:0] ANGLE_RND =
    ACC_WIDTH'(1) << (ACC_WIDTH - ANGLE_WIDTH - 1);

  logic [AW-1:0]            a_u;
  logic [LO_W+GAIN_WIDTH-1:0] p_lo;
  logic [HI_W+GAIN_WIDTH-1:0] p_hi;
  logic [ACC_WIDTH-1:0]     acc_d1;
  r2p_ctl_t                 ctl1;
  logic [PW-1:0]            sum;
  logic [ACC_WIDTH-1:0]     acc_rnd;
  logic [MW-1:0]            mag_w;
  logic [ANGLE_WIDTH-1:0]   angle_r;
  r2p_ctl_t                 ctl2;

  // a negative final x is clamped to zero
  assign a_u = x_in[XW-1] ? '0 : x_in[AW-1:0];

  // split multiply, halves in parallel
  always_ff @(posedge clk) begin
    p_lo   <= a_u[LO_W-1:0] * GAIN;
    p_hi   <= a_u[AW-1:LO_W] * GAIN;
    acc_d1 <= acc_in;
  end

  assign sum     = (PW'(p_hi) << LO_W) + PW'(p_lo) + RND;
  assign acc_rnd = acc_d1 + ANGLE_RND;

  always_ff @(posedge clk) begin
    mag_w   <= sum[PW-1:SCALE_SHIFT];
    angle_r <= ctl1.zero ? '0 : acc_rnd[ACC_WIDTH-1 -: ANGLE_WIDTH];
  end

  // saturate and register the result
  always_ff @(posedge clk) begin
    if (ctl2.zero) begin
      magnitude <= '0;
    end else if (|mag_w[MW-1:COORD_WIDTH]) begin
      magnitude <= '1;
    end else begin
      magnitude <= mag_w[COORD_WIDTH-1:0];
    end
    angle <= angle_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      done <= 1'b0;
    end else begin
      ctl1 <= ctl_in;
      ctl2 <= ctl1;
      done <= ctl2.valid;
    end
  end

endmodule

[hdl/rect_to_polar_converter.sv]
// ----------------------------------------------------------------------------
// rect_to_polar_converter
// cartesian point to magnitude and binary angle by pipelined cordic vectoring
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   start, busy        x_coord, y_coord   (signed COORD_WIDTH)
//  result    done (1 cycle)     magnitude (unsigned COORD_WIDTH),
//                               angle (signed 16, 32768 counts = pi)
//
//  a request is taken on any edge with start high and busy low; busy stays low,
//  so one point enters every cycle
//  each result passes through the input register, one cell per cordic stage,
//  two gain-multiply stages and the output reg
//  rst is synchronous and clears only the valid pipeline; data regs free-run
//  done is a one-cycle strobe, the receiver cannot hold results off
// ----------------------------------------------------------------------------
module rect_to_polar_converter
  import r2p_pkg::*;
#(
  parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  output logic                          done,
  output logic        [COORD_WIDTH-1:0] magnitude,
  output logic signed [ANGLE_WIDTH-1:0] angle
);

  // working width: sign, folded-axis growth, cordic gain headroom, guard bits
  localparam int XW = COORD_WIDTH + GUARD_BITS + 3;

  logic signed [XW-1:0]        x_pipe   [0:CORDIC_STAGES];
  logic signed [XW-1:0]        y_pipe   [0:CORDIC_STAGES];
  logic        [ACC_WIDTH-1:0] acc_pipe [0:CORDIC_STAGES];
  r2p_ctl_t                    ctl_pipe [0:CORDIC_STAGES];

  // fully pipelined, never stalls a request
  assign busy = 1'b0;

  // fold the left half plane onto the right, seed the angle with pi there
  r2p_prep #(
    .COORD_WIDTH (COORD_WIDTH),
    .XW          (XW)
  ) u_prep (
    .clk     (clk),
    .rst     (rst),
    .accept  (start && !busy),
    .x_coord (x_coord),
    .y_coord (y_coord),
    .x_out   (x_pipe[0]),
    .y_out   (y_pipe[0]),
    .acc_out (acc_pipe[0]),
    .ctl_out (ctl_pipe[0])
  );

  // row of micro-rotation cells, cell i shifts by i and uses atan(2^-i)
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    r2p_cell #(
      .XW    (XW),
      .SHIFT (i),
      .ATAN  (atan_entry(i))
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .x_in    (x_pipe[i]),
      .y_in    (y_pipe[i]),
      .acc_in  (acc_pipe[i]),
      .ctl_in  (ctl_pipe[i]),
      .x_out   (x_pipe[i+1]),
      .y_out   (y_pipe[i+1]),
      .acc_out (acc_pipe[i+1]),
      .ctl_out (ctl_pipe[i+1])
    );
  end

  // residual y is not needed past the last cell
  // gain compensation, saturation and angle rounding
  r2p_gain #(
    .COORD_WIDTH (COORD_WIDTH),
    .XW          (XW),
    .STAGES      (CORDIC_STAGES)
  ) u_gain (
    .clk       (clk),
    .rst       (rst),
    .x_in      (x_pipe[CORDIC_STAGES]),
    .acc_in    (acc_pipe[CORDIC_STAGES]),
    .ctl_in    (ctl_pipe[CORDIC_STAGES]),
    .done      (done),
    .magnitude (magnitude),
    .angle     (angle)
  );

endmodule

[hdl/r2p_checker.sv]
// ----------------------------------------------------------------------------
// r2p_checker
// port-level checks of request to result timing and special-case angles
// ----------------------------------------------------------------------------
`include "rect_to_polar_converter_defines.svh"

module r2p_checker
  import r2p_pkg::*;
#(
  parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic signed [COORD_WIDTH-1:0] x_coord,
  input logic signed [COORD_WIDTH-1:0] y_coord,
  input logic                          done,
  input logic        [COORD_WIDTH-1:0] magnitude,
  input logic signed [ANGLE_WIDTH-1:0] angle
);

  localparam int LATENCY = CORDIC_STAGES + PIPE_EXTRA;
  localparam logic signed [ANGLE_WIDTH-1:0] MINUS_PI = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};

  logic req_taken;
  logic origin_req;
  logic neg_axis_req;

  assign req_taken    = start && !busy;
  assign origin_req   = (x_coord == '0) && (y_coord == '0);
  assign neg_axis_req = x_coord[COORD_WIDTH-1] && (y_coord == '0);

  `R2P_ASSERT_DELAY(a_req_gives_result, req_taken, LATENCY, done)
  `R2P_ASSERT_IMP(a_result_had_req, done, $past(req_taken, LATENCY))
  `R2P_ASSERT_IMP(a_origin_zero, done && $past(origin_req, LATENCY), magnitude == '0 && angle == '0)
  `R2P_ASSERT_IMP(a_neg_axis_minus_pi, done && $past(neg_axis_req, LATENCY), angle == MINUS_PI)

endmodule

bind rect_to_polar_converter r2p_checker #(
  .COORD_WIDTH   (COORD_WIDTH),
  .CORDIC_STAGES (CORDIC_STAGES)
) u_r2p_checker (.*);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// regression for the rectangular to polar converter: points go in at one per
// cycle with random gaps, each result is checked against a bit-exact fixed
// point cordic vectoring predictor running beside the pipeline
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import r2p_pkg::*;

  localparam int CW     = DEF_COORD_WIDTH;
  localparam int STAGES = DEF_CORDIC_STAGES;
  // latency of one request through the pipeline
  localparam int LATENCY = STAGES + PIPE_EXTRA;

  localparam logic signed [CW-1:0] MIN_COORD = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] MAX_COORD = {1'b0, {(CW-1){1'b1}}};

  // rotation angle of each micro-rotation, 2^31 counts per half turn
  localparam bit [31:0] ROT_STEP [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // gain correction in q31 by stage count, sixteen and up share the last one
  localparam bit [31:0] GAIN_FIX [0:16] = '{
    32'd2147483648, 32'd1518500250, 32'd1358187914, 32'd1317635818,
    32'd1307460872, 32'd1304914694, 32'd1304277995, 32'd1304118810,
    32'd1304079014, 32'd1304069064, 32'd1304066577, 32'd1304065955,
    32'd1304065800, 32'd1304065761, 32'd1304065751, 32'd1304065749,
    32'd1304065748
  };

  typedef struct {
    logic signed [CW-1:0]          x;
    logic signed [CW-1:0]          y;
    logic [CW-1:0]                 mag;
    logic signed [ANGLE_WIDTH-1:0] ang;
  } polar_point_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic signed [CW-1:0]          x_coord = '0;
  logic signed [CW-1:0]          y_coord = '0;
  logic                          done;
  logic [CW-1:0]                 magnitude;
  logic signed [ANGLE_WIDTH-1:0] angle;

  // polar results still owed by the pipeline, oldest first
  polar_point_t pending_polar[$];
  int           mismatch_count = 0;

  rect_to_polar_converter #(
    .COORD_WIDTH   (CW),
    .CORDIC_STAGES (STAGES)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .done      (done),
    .magnitude (magnitude),
    .angle     (angle)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // generous ceiling, a clean run takes a small fraction of this
  initial begin
    #200_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // fixed point cordic vectoring of one point
  // left half plane is folded over by a half turn before the micro-rotations
  function automatic polar_point_t polar_of_point(input logic signed [CW-1:0] px,
                                                  input logic signed [CW-1:0] py);
    polar_point_t r;
    longint       xs;
    longint       ys;
    longint       a;
    longint       b;
    longint       da;
    longint       db;
    bit [31:0]    phase;
    bit [31:0]    phase_rnd;
    bit [63:0]    a_pos;
    bit [95:0]    prod;
    bit [95:0]    mag_full;
    int           gidx;
    r.x   = px;
    r.y   = py;
    xs    = px;
    ys    = py;
    phase = '0;
    // origin has no direction, angle reported as zero
    if (xs == 0 && ys == 0) begin
      r.mag = '0;
      r.ang = '0;
      return r;
    end
    if (xs < 0) begin
      xs    = -xs;
      ys    = -ys;
      phase = 32'h8000_0000;
    end
    a = xs * (longint'(1) << GUARD_BITS);
    b = ys * (longint'(1) << GUARD_BITS);
    for (int i = 0; i < STAGES && i < 32; i++) begin
      // arithmetic shifts round toward minus infinity
      da = b >>> i;
      db = a >>> i;
      if (b >= 0) begin
        a     = a + da;
        b     = b - db;
        phase = phase + ROT_STEP[i];
      end else begin
        a     = a - da;
        b     = b + db;
        phase = phase - ROT_STEP[i];
      end
    end
    gidx     = (STAGES > 16) ? 16 : STAGES;
    a_pos    = (a < 0) ? 64'd0 : 64'(a);
    // round half up after dropping q31 gain and guard bits
    prod     = {32'd0, a_pos} * {64'd0, GAIN_FIX[gidx]} + (96'd1 << (GAIN_FRAC + GUARD_BITS - 1));
    mag_full = prod >> (GAIN_FRAC + GUARD_BITS);
    if (mag_full > {{(96-CW){1'b0}}, {CW{1'b1}}}) r.mag = '1;
    else r.mag = mag_full[CW-1:0];
    // half turn lands on the most negative code, plus pi is out of range
    phase_rnd = phase + 32'h0000_8000;
    r.ang     = phase_rnd[31:32-ANGLE_WIDTH];
    return r;
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    $display("%0t ns %s", $time, msg);
  endtask

  // one request, held until the converter takes it
  task automatic send_point(input logic signed [CW-1:0] px,
                            input logic signed [CW-1:0] py);
    start   <= 1'b1;
    x_coord <= px;
    y_coord <= py;
    do @(posedge clk); while (busy);
    pending_polar.push_back(polar_of_point(px, py));
  endtask

  // sender idles for a few cycles
  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // sender waits until every owed result has come back
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_polar.size() != 0);
  endtask

  function automatic logic signed [CW-1:0] edge_coord();
    case ($urandom_range(0, 6))
      0:       return MIN_COORD;
      1:       return MIN_COORD + CW'(1);
      2:       return CW'(-1);
      3:       return '0;
      4:       return CW'(1);
      5:       return MAX_COORD - CW'(1);
      default: return MAX_COORD;
    endcase
  endfunction

  function automatic logic signed [CW-1:0] near_zero(input int span);
    return CW'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // origin, both axes in both directions, unit steps off the origin
  task automatic test_special_points();
    send_point(0, 0);
    send_point(MAX_COORD, 0);
    send_point(MIN_COORD, 0);
    send_point(-1, 0);
    // negative x axis reported as minus pi
    send_point(-12345, 0);
    send_point(1, 0);
    send_point(0, 1);
    hold_off(3);
    send_point(0, -1);
    send_point(0, MAX_COORD);
    send_point(0, MIN_COORD);
    send_point(0, 0);
  endtask

  // corners of the input square, the diagonals and points hugging the axes
  task automatic test_extreme_corners();
    send_point(MAX_COORD, MAX_COORD);
    send_point(MIN_COORD, MIN_COORD);
    send_point(MAX_COORD, MIN_COORD);
    send_point(MIN_COORD, MAX_COORD);
    hold_off(5);
    send_point(MIN_COORD, -1);
    send_point(MIN_COORD, 1);
    send_point(1, 1);
    send_point(-1, -1);
    send_point(-1, 1);
    send_point(1, -1);
    send_point(100, -100);
    send_point(MAX_COORD, 1);
  endtask

  // random points in mixed shapes, idling switched on and off in stretches
  task automatic test_random_points(input int n);
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] t;
    bit                   idle_on;
    idle_on = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (idle_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 7));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          px = CW'($urandom);
          py = CW'($urandom);
        end
        4: begin
          px = near_zero(32);
          py = near_zero(32);
        end
        5: begin
          // close to an axis
          px = CW'($urandom);
          py = near_zero(8);
          if ($urandom_range(0, 1) == 1) begin
            t  = px;
            px = py;
            py = t;
          end
        end
        6: begin
          // close to a diagonal
          px = CW'($urandom);
          py = ($urandom_range(0, 1) == 1) ? px + near_zero(4) : -px + near_zero(4);
        end
        7: begin
          px = edge_coord();
          py = edge_coord();
        end
        8: begin
          px = edge_coord();
          py = CW'($urandom);
          if ($urandom_range(0, 1) == 1) begin
            t  = px;
            px = py;
            py = t;
          end
        end
        default: begin
          px = near_zero(1024);
          py = near_zero(1024);
        end
      endcase
      send_point(px, py);
    end
  endtask

  // let the pipeline empty fully, then restart into it
  task automatic test_drain_pause();
    wait_for_drain();
    send_point(MIN_COORD, 0);
    send_point(3, -4);
    wait_for_drain();
  endtask

  // tail of the run with a request on every cycle
  task automatic test_back_to_back(input int n);
    for (int k = 0; k < n; k++) begin
      send_point(CW'($urandom), CW'($urandom));
    end
  endtask

  // every result is checked against the oldest owed one
  always @(posedge clk) begin
    polar_point_t want;
    if (!rst && done) begin
      if (pending_polar.size() == 0) begin
        flag_error($sformatf("result with no request owed: expected none, actual mag %0d ang %0d",
                             magnitude, angle));
      end else begin
        want = pending_polar.pop_front();
        if (magnitude !== want.mag)
          flag_error($sformatf("magnitude of (%0d,%0d): expected %0d, actual %0d",
                               want.x, want.y, want.mag, magnitude));
        if (angle !== want.ang)
          flag_error($sformatf("angle of (%0d,%0d): expected %0d, actual %0d",
                               want.x, want.y, want.ang, angle));
      end
    end
  end

  initial begin
    // synchronous reset held at the start, then released
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_special_points();
    test_extreme_corners();
    test_random_points(600);
    test_drain_pause();
    test_random_points(450);
    test_back_to_back(280);

    // all requests taken, collect the rest and watch for stray strobes
    wait_for_drain();
    repeat (2 * LATENCY) @(posedge clk);

    if (mismatch_count == 0 && pending_polar.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
